// ===== src/sspq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_pkg: shared definitions for the stable sorted priority queue
// Field widths, command and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int CMD_W = 2;
  localparam int ID_W  = 16;
  localparam int PRI_W = 16;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic execute;  // apply the request to the slots and load the result
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== src/sspq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_ctrl: request sequencer
// Accepts one request, runs it in the following cycle once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sspq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sspq_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (cmd.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // A new result replaces the old one only once the old one is taken.
          if (cmd.execute) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/sspq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_datapath: sorted slot array and result register
// Every slot compares its priority with the new one in parallel; an enqueue
// shifts the tail down one slot, a dequeue shifts all slots up one slot.
// ----------------------------------------------------------------------------
module sspq_datapath #(
  parameter int CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sspq_pkg::ctrl_cmd_t               cmd,
  input  wire logic [sspq_pkg::CMD_W-1:0]        command,
  input  wire logic [sspq_pkg::ID_W-1:0]         process_id,
  input  wire logic signed [sspq_pkg::PRI_W-1:0] priority_req,
  output logic [sspq_pkg::ID_W-1:0]              front_id,
  output logic [sspq_pkg::ST_W-1:0]              status,
  output logic [sspq_pkg::OCC_W-1:0]             occupancy,
  output logic                                   is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic [sspq_pkg::CMD_W-1:0]        cmd_q;
  logic [sspq_pkg::ID_W-1:0]         id_q;
  logic signed [sspq_pkg::PRI_W-1:0] pri_q;

  logic signed [sspq_pkg::PRI_W-1:0] slot_pri      [CAPACITY];
  logic [sspq_pkg::ID_W-1:0]         slot_id       [CAPACITY];
  logic signed [sspq_pkg::PRI_W-1:0] slot_pri_next [CAPACITY];
  logic [sspq_pkg::ID_W-1:0]         slot_id_next  [CAPACITY];
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  count_next;

  logic [CAPACITY-1:0]               le;
  logic                              full;
  logic                              empty;
  logic                              do_enq;
  logic                              do_deq;
  logic [sspq_pkg::ID_W-1:0]         front_next;
  logic [sspq_pkg::ST_W-1:0]         status_next;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);

  // Occupied slots at or below the new priority form a prefix of the array.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (CNT_W'(i) < count) && (slot_pri[i] <= pri_q);
    end
  end

  always_comb begin
    do_enq      = 1'b0;
    do_deq      = 1'b0;
    front_next  = '0;
    status_next = sspq_pkg::ST_OK;
    unique case (cmd_q)
      sspq_pkg::CMD_ENQ: begin
        if (full) begin
          status_next = sspq_pkg::ST_FULL;
        end else begin
          do_enq = 1'b1;
        end
      end
      sspq_pkg::CMD_DEQ: begin
        if (empty) begin
          status_next = sspq_pkg::ST_EMPTY;
        end else begin
          do_deq     = 1'b1;
          front_next = slot_id[0];
        end
      end
      sspq_pkg::CMD_PEEK: begin
        if (empty) begin
          status_next = sspq_pkg::ST_EMPTY;
        end else begin
          front_next = slot_id[0];
        end
      end
      default: begin
        status_next = sspq_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + CNT_W'(1);
    end else if (do_deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_pri_next[i] = slot_pri[i];
      slot_id_next[i]  = slot_id[i];
      if (do_enq) begin
        if (!le[i]) begin
          if (i == 0) begin
            slot_pri_next[i] = pri_q;
            slot_id_next[i]  = id_q;
          end else if (le[i-1]) begin
            slot_pri_next[i] = pri_q;
            slot_id_next[i]  = id_q;
          end else begin
            slot_pri_next[i] = slot_pri[i-1];
            slot_id_next[i]  = slot_id[i-1];
          end
        end
      end else if (do_deq) begin
        if (i < CAPACITY - 1) begin
          slot_pri_next[i] = slot_pri[i+1];
          slot_id_next[i]  = slot_id[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= command;
      id_q  <= process_id;
      pri_q <= priority_req;
    end
    if (cmd.execute) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_pri[i] <= slot_pri_next[i];
        slot_id[i]  <= slot_id_next[i];
      end
      front_id  <= front_next;
      status    <= status_next;
      occupancy <= sspq_pkg::OCC_W'(count_next);
      is_empty  <= (count_next == '0);
    end
  end

endmodule
`default_nettype wire

// ===== src/stable_sorted_priority_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit: bounded, stable sorted priority queue
// Enqueue, dequeue-front and peek-front on a sorted slot array; lower
// priority values leave first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ------------------------------------------
//   request   in_valid / in_ready     command, process_id, priority_req
//   result    out_valid / out_ready   front_id, status, occupancy, is_empty
//
// A request is latched in the cycle it is accepted and is applied to all
// slots at once in the execute state, when the result register loads.
// The result register lets a new request be accepted while a result waits.
// A stalled result holds the execute state until out_ready frees the register.
// Synchronous reset empties the queue; slot contents are not cleared, since
// only occupied slots are ever read.
//
module stable_sorted_priority_queue_unit #(
  parameter int CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sspq_pkg::CMD_W-1:0]        command,
  input  wire logic [sspq_pkg::ID_W-1:0]         process_id,
  input  wire logic signed [sspq_pkg::PRI_W-1:0] priority_req,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sspq_pkg::ID_W-1:0]              front_id,
  output logic [sspq_pkg::ST_W-1:0]              status,
  output logic [sspq_pkg::OCC_W-1:0]             occupancy,
  output logic                                   is_empty
);

  sspq_pkg::ctrl_cmd_t cmd;

  sspq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sspq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .command      (command),
    .process_id   (process_id),
    .priority_req (priority_req),
    .front_id     (front_id),
    .status       (status),
    .occupancy    (occupancy),
    .is_empty     (is_empty)
  );

endmodule
`default_nettype wire

// ===== src/sspq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sspq_checker: port-level checks for the priority queue
// Watches the top-level ports and flags results and handshakes that cannot occur.
// ----------------------------------------------------------------------------
module sspq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sspq_pkg::ID_W-1:0]  front_id,
  input wire logic [sspq_pkg::ST_W-1:0]  status,
  input wire logic [sspq_pkg::OCC_W-1:0] occupancy,
  input wire logic                       is_empty
);

  // A stalled result must hold still.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(front_id) && $stable(status)
      && $stable(occupancy) && $stable(is_empty))
    else $error("result changed while stalled");

  // One request is in flight at a time, so acceptance closes the request side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> occupancy == '0)
    else $error("empty flag set with nonzero occupancy");

  // A refused or empty request never reports an id, and empty status means empty.
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sspq_pkg::ST_EMPTY || status == sspq_pkg::ST_FULL)
      |-> front_id == '0 && (status != sspq_pkg::ST_EMPTY || is_empty))
    else $error("error status with inconsistent result");

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .front_id  (front_id),
  .status    (status),
  .occupancy (occupancy),
  .is_empty  (is_empty)
);
`default_nettype wire
